// ----- src/sample_without_replacement_defines.svh -----
// Assertion macros for the sample_without_replacement block.
`ifndef SAMPLE_WITHOUT_REPLACEMENT_DEFINES_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_DEFINES_SVH

// Check cons in the same cycle as ante; uses the module's clk and rst.
`define SWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/swr_pkg.sv -----
// Shared constants for the sample_without_replacement block.
package swr_pkg;

  localparam int DEFAULT_POOL_DEPTH = 256;
  localparam int DATA_W             = 32;
  localparam int SPAN_W             = 9;
  localparam int PADDR_W            = 3;
  localparam int PDATA_W            = 32;

  localparam logic REG_VALUE_BASE = 1'b0;
  localparam logic REG_POOL_SPAN  = 1'b1;

endpackage

// ----- src/sample_without_replacement.sv -----
// Sampler without replacement: partial shuffle with an iterative modulo unit.
//
// Input channel (valid/ready) carries random_word and start_run; output
// channel (valid/ready) carries drawn_value and status. start_run refills
// the pool with min(pool_span, POOL_DEPTH) values before the draw. Each
// draw returns value_base + 1 + offset of slot (random_word mod remaining),
// then the last live slot moves into the picked slot. An empty pool gives
// status 1 and drawn_value 0 and leaves the pool alone.
// A draw runs 32 restoring-division steps, one bit per cycle, then two
// slot-table reads and one write; an empty pool goes straight to the
// final write step. A word is taken only once the last one has left the
// final step, so in_ready is high only between words.
// When the receiver stalls, the finished word is held in the output register
// and the next input word is still taken; its result waits in the final
// step until the output register frees.
// Reset (synchronous): pool empty, written map cleared, config registers, state and out_valid zero.
// The slot table itself needs no clearing; a per-slot written bit covers it.
// Config: APB, value_base at 0x0, pool_span at 0x4; write only while idle.
`include "sample_without_replacement_defines.svh"

module sample_without_replacement #(
  parameter int POOL_DEPTH = swr_pkg::DEFAULT_POOL_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swr_pkg::PADDR_W-1:0] paddr,
  input  logic [swr_pkg::PDATA_W-1:0] pwdata,
  output logic [swr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swr_pkg::DATA_W-1:0]  random_word,
  input  logic                        start_run,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swr_pkg::DATA_W-1:0]  drawn_value,
  output logic                        status
);
  import swr_pkg::*;

  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;
  localparam int STEP_W = $clog2(DATA_W);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV     = 3'd1;
  localparam logic [2:0] ST_RD_SLOT = 3'd2;
  localparam logic [2:0] ST_RD_LAST = 3'd3;
  localparam logic [2:0] ST_WRITE   = 3'd4;

  logic [2:0]            state;
  logic [DATA_W-1:0]     value_base;
  logic [SPAN_W-1:0]     pool_span;
  logic [CNT_W-1:0]      count;
  logic [POOL_DEPTH-1:0] written;
  logic [DATA_W-1:0]     quo;
  logic [CNT_W-1:0]      rem;
  logic [STEP_W-1:0]     step;
  logic                  empty;
  logic [IDX_W-1:0]      picked;
  logic [IDX_W-1:0]      rdata;
  logic [IDX_W-1:0]      raddr;
  logic [IDX_W-1:0]      mem [POOL_DEPTH];

  logic [CMP_W-1:0]      span_ext;
  logic [CNT_W-1:0]      count_sat;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      last;
  logic [IDX_W-1:0]      move_ofs;
  logic                  in_fire;
  logic                  cfg_wr;
  logic                  out_free;
  logic                  finish;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_VALUE_BASE) ? value_base : PDATA_W'(pool_span);
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == ST_WRITE) && out_free;

  assign span_ext   = CMP_W'(pool_span);
  assign count_sat  = (span_ext > CMP_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH)
                                                      : CNT_W'(span_ext);
  assign count_next = start_run ? count_sat : count;

  assign trial    = {rem, quo[DATA_W-1]};
  assign diff     = trial - {1'b0, count};
  assign slot     = rem[IDX_W-1:0];
  assign last     = IDX_W'(count - CNT_W'(1));
  assign move_ofs = written[last] ? rdata : last;

  always_comb begin
    raddr = slot;
    if (state == ST_RD_LAST || state == ST_WRITE) begin
      raddr = last;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (finish && !empty) begin
      mem[slot] <= move_ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_base <= '0;
      pool_span  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_VALUE_BASE: value_base <= pwdata;
        REG_POOL_SPAN:  pool_span  <= pwdata[SPAN_W-1:0];
        default:        value_base <= value_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      written   <= '0;
      empty     <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (start_run) begin
              written <= '0;
            end
            count <= count_next;
            quo   <= random_word;
            rem   <= '0;
            step  <= '0;
            empty <= (count_next == '0);
            state <= (count_next == '0) ? ST_WRITE : ST_DIV;
          end
        end
        ST_DIV: begin
          quo  <= quo << 1;
          step <= step + STEP_W'(1);
          if (trial >= {1'b0, count}) begin
            rem <= diff[CNT_W-1:0];
          end else begin
            rem <= trial[CNT_W-1:0];
          end
          if (step == STEP_W'(DATA_W - 1)) begin
            state <= ST_RD_SLOT;
          end
        end
        ST_RD_SLOT: begin
          state <= ST_RD_LAST;
        end
        ST_RD_LAST: begin
          picked <= written[slot] ? rdata : slot;
          state  <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (empty) begin
              drawn_value <= '0;
              status      <= 1'b1;
            end else begin
              drawn_value   <= value_base + DATA_W'(1) + DATA_W'(picked);
              status        <= 1'b0;
              written[slot] <= 1'b1;
              count         <= count - CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SWR_ASSERT_NOW(a_count_in_range, 1'b1, count <= CNT_W'(POOL_DEPTH), "pool count beyond depth")
  `SWR_ASSERT_NOW(a_rem_below_count, state == ST_DIV, rem < count, "remainder not below count")
  `SWR_ASSERT_NEXT(a_draw_shrinks, finish && !empty, count == $past(count) - CNT_W'(1), "count not decremented")
  `SWR_ASSERT_NOW(a_empty_word_zero, out_valid && status, drawn_value == '0, "empty word carries a value")

endmodule

// ----- bench/tb_sample_without_replacement.sv -----
// Self-checking testbench for the sample_without_replacement partial-shuffle sampler.
module tb_sample_without_replacement;
  import swr_pkg::*;

  localparam int DEPTH        = DEFAULT_POOL_DEPTH;
  localparam int MAX_IDLE     = 18;
  localparam int SETTLE       = 40;
  localparam int TARGET_WORDS = 2000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              empty;
  } draw_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [DATA_W-1:0]  random_word = '0;
  logic               start_run = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic [DATA_W-1:0]  drawn_value;
  logic               status;

  sample_without_replacement dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .random_word(random_word), .start_run(start_run),
    .out_valid(out_valid), .out_ready(out_ready),
    .drawn_value(drawn_value), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the sampler state
  logic [DATA_W-1:0] base_reg = '0;
  logic [SPAN_W-1:0] span_reg = '0;
  logic [7:0]        slot_offset [DEPTH];
  bit                slot_moved [DEPTH];
  logic [SPAN_W-1:0] live_slots = '0;

  draw_result_t pending_draws[$];
  bit           idling = 1'b1;
  int           hold_cycles = 0;
  int           mismatches = 0;
  int           words_sent = 0;
  int           draws_seen = 0;
  int           empty_seen = 0;
  int           refills_sent = 0;
  int           reg_writes = 0;

  initial slot_moved = '{default: 1'b0};

  function automatic logic [7:0] held_offset(input int unsigned slot);
    return slot_moved[slot] ? slot_offset[slot] : 8'(slot);
  endfunction

  function automatic void predict_draw(input logic [DATA_W-1:0] word, input logic refill);
    int unsigned  slot;
    int unsigned  last;
    logic [7:0]   picked;
    draw_result_t res;
    if (refill) begin
      slot_moved = '{default: 1'b0};
      live_slots = (span_reg > SPAN_W'(DEPTH)) ? SPAN_W'(DEPTH) : span_reg;
    end
    if (live_slots == 0) begin
      res.value = '0;
      res.empty = 1'b1;
    end else begin
      slot = word % {23'b0, live_slots};
      last = live_slots - 1;
      picked = held_offset(slot);
      slot_offset[slot] = held_offset(last);
      slot_moved[slot] = 1'b1;
      live_slots = SPAN_W'(last);
      res.value = base_reg + 32'd1 + 32'(picked);
      res.empty = 1'b0;
    end
    pending_draws.push_back(res);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(0, 600));
      default: return $urandom;
    endcase
  endfunction

  // Call at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic [DATA_W-1:0] word, input logic refill);
    int gap;
    gap = idling ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    random_word <= word;
    start_run <= refill;
    do @(posedge clk); while (!in_ready);
    predict_draw(word, refill);
    words_sent++;
    if (refill) refills_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_VALUE_BASE) begin
      base_reg = data;
      readback = data;
    end else begin
      span_reg = data[SPAN_W-1:0];
      readback = {23'b0, data[SPAN_W-1:0]};
    end
    reg_writes++;
    if (prdata !== readback) begin
      if (mismatches < 10)
        $display("register %0d readback: expected %h got %h", idx, readback, prdata);
      mismatches++;
    end
  endtask

  task automatic configure(input logic [DATA_W-1:0] base, input logic [SPAN_W-1:0] span);
    drain();
    write_reg(REG_VALUE_BASE, base);
    write_reg(REG_POOL_SPAN, {23'b0, span});
  endtask

  task automatic check_draw();
    draw_result_t exp_res;
    if (pending_draws.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected word: value %h status %0d", drawn_value, status);
      mismatches++;
    end else begin
      exp_res = pending_draws.pop_front();
      if (exp_res.empty) empty_seen++;
      else draws_seen++;
      if (drawn_value !== exp_res.value || status !== exp_res.empty) begin
        if (mismatches < 10)
          $display("draw mismatch: expected value %h status %0d, got value %h status %0d",
                   exp_res.value, exp_res.empty, drawn_value, status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        check_draw();
        hold_cycles = idling ? $urandom_range(0, MAX_IDLE) : 0;
        if (hold_cycles != 0) out_ready <= 1'b0;
      end else if (out_valid && !out_ready) begin
        hold_cycles--;
        if (hold_cycles <= 0) out_ready <= 1'b1;
      end
    end
  end

  task automatic test_unrefilled_pool();
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word($urandom, 1'b0);
  endtask

  task automatic test_directed_cases();
    configure('0, 9'd0);
    send_word($urandom, 1'b1);
    send_word($urandom, 1'b0);
    configure('0, 9'd1);
    send_word('1, 1'b1);
    send_word('0, 1'b0);
    configure('1, 9'd3);
    send_word('1, 1'b1);
    send_word('0, 1'b0);
    send_word(32'd5, 1'b0);
    send_word('0, 1'b0);
    configure(32'hFFFF_FF00, 9'd256);
    send_word('0, 1'b1);
    send_word('1, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'd255, 1'b0);
    // change both registers mid-run; only the base applies before a refill
    drain();
    write_reg(REG_VALUE_BASE, 32'h1234_5678);
    write_reg(REG_POOL_SPAN, 32'd2);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b1);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b0);
    configure(32'h7FFF_FFFF, 9'd511);
    send_word($urandom, 1'b1);
    send_word('1, 1'b0);
    configure('0, 9'd257);
    send_word(32'd256, 1'b1);
    send_word('1, 1'b0);
  endtask

  task automatic test_full_pool();
    configure($urandom, 9'd256);
    send_word(pick_word(), 1'b1);
    repeat (DEPTH) send_word(pick_word(), 1'b0);
  endtask

  task automatic test_random_runs();
    logic [DATA_W-1:0] base;
    logic [SPAN_W-1:0] span;
    int                eff;
    int                len;
    int                kind;
    bit                noisy;
    while (words_sent < TARGET_WORDS) begin
      idling = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0: base = '0;
        1: base = '1;
        2: base = 32'hFFFF_FF80;
        default: base = $urandom;
      endcase
      case ($urandom_range(0, 15))
        0: span = '0;
        1: span = SPAN_W'($urandom_range(256, 511));
        2: span = SPAN_W'($urandom_range(100, 256));
        default: span = SPAN_W'($urandom_range(1, 24));
      endcase
      configure(base, span);
      repeat ($urandom_range(1, 4)) begin
        eff = (span_reg > SPAN_W'(DEPTH)) ? DEPTH : int'(span_reg);
        kind = $urandom_range(0, 9);
        noisy = (kind == 9);
        if (kind <= 6) len = eff + $urandom_range(0, 2);
        else if (!noisy) len = $urandom_range(1, eff + 1);
        else len = $urandom_range(1, 12);
        if (len < 1) len = 1;
        for (int k = 0; k < len; k++) begin
          send_word(pick_word(), (k == 0) || (noisy && $urandom_range(0, 3) == 0));
          if (!noisy && k == len / 2 && $urandom_range(0, 7) == 0) begin
            drain();
            write_reg(REG_VALUE_BASE, $urandom);
            if ($urandom_range(0, 1) != 0)
              write_reg(REG_POOL_SPAN, 32'($urandom_range(0, 511)));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unrefilled_pool();
    test_directed_cases();
    test_full_pool();
    test_random_runs();
    drain();
    if (pending_draws.size() != 0) mismatches++;
    $display("sent %0d words (%0d refills) over %0d register writes", words_sent,
             refills_sent, reg_writes);
    $display("checked %0d draws and %0d empty-pool results, %0d mismatches", draws_seen,
             empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_sample_without_replacement: PASS");
    end else begin
      $display("tb_sample_without_replacement: FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd12 * 64'd800_000);
    $display("timeout");
    $display("tb_sample_without_replacement: FAIL");
    $finish;
  end

endmodule
